// ----- design/cpu_register_alu_step_defines.svh -----
// Assertion macros for the cpu_register_alu_step design files.
`ifndef CPU_REGISTER_ALU_STEP_DEFINES_SVH
`define CPU_REGISTER_ALU_STEP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cra_pkg.sv -----
// Types, opcode fields and helpers for the 8-bit register/ALU step block.
`timescale 1ns / 1ps

package cra_pkg;

    localparam int REG_COUNT = 7;

    typedef logic [2:0] t_reg_idx;
    typedef logic [2:0] t_reg_code;

    // Register file indexes
    localparam t_reg_idx REG_A = 3'd0;
    localparam t_reg_idx REG_H = 3'd5;
    localparam t_reg_idx REG_L = 3'd6;

    // Source/destination codes in the opcode
    localparam t_reg_code CODE_HL = 3'd6;
    localparam t_reg_code CODE_A  = 3'd7;

    // Opcode groups, op[7:6]
    localparam logic [1:0] OPG_LOAD    = 2'b01;
    localparam logic [1:0] OPG_ALU_REG = 2'b10;
    localparam logic [1:0] OPG_ALU_IMM = 2'b11;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_ADC,
        ALU_SUB,
        ALU_SBC,
        ALU_AND,
        ALU_XOR,
        ALU_OR,
        ALU_CP
    } t_alu_op;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    typedef struct packed {
        logic [7:0] op;
        logic [7:0] operand;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  result_value;
        logic        zero_flag;
        logic        subtract_flag;
        logic        half_carry_flag;
        logic        carry_flag;
        logic [15:0] hl_address;
        logic        known;
    } t_out_item;

    // Code 7 is A; code 6 is the memory operand and also maps to the index of A.
    function automatic t_reg_idx code_to_index(input t_reg_code code);
        if (code == CODE_A || code == CODE_HL) begin
            return REG_A;
        end
        return code + 3'd1;
    endfunction

endpackage

// ----- design/cra_stream_if.sv -----
// Valid/ready stream interface carrying one item per handshake.
`timescale 1ns / 1ps

interface cra_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/cpu_register_alu_step.sv -----
// Top level: one 8-bit load/ALU instruction per item against A..L and Z/N/H/C.
// Each accepted item is held in an input register, executed combinationally
// against the register file and flags, and its result item lands in an output
// register while the register file and flags are written at the same edge.
// Throughput is one item per clock while the output side takes each result; an
// accepted item passes the input register and then the output register. The
// rate is set by the single execute stage, whose write-back is complete before
// the next item reads the registers. The input side keeps taking items while a
// result waits on the output side, until both registers are full. Unsupported
// opcodes change no state and report known=0 with a zero result value.
`timescale 1ns / 1ps
`include "cpu_register_alu_step_defines.svh"

module cpu_register_alu_step (
    input logic          i_clk,
    input logic          i_rst_n,
    cra_stream_if.sink   i_in,
    cra_stream_if.source o_out
);
    import cra_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic [7:0] r_regs [REG_COUNT];
    t_flags     r_flags;

    logic       out_free;
    logic       ex_fire;
    logic [7:0] op;
    t_reg_code  dst_code;
    t_reg_code  src_code;
    t_reg_idx   dst_idx;
    t_reg_idx   src_idx;
    logic [7:0] src_val;
    logic       ld_ok;
    logic       alu_en;
    logic       write_a;
    logic [7:0] alu_b;
    t_alu_op    alu_kind;
    logic [7:0] alu_res;
    t_flags     alu_flags;
    t_flags     n_flags;
    logic [7:0] n_h;
    logic [7:0] n_l;
    t_out_item  n_out;

    assign out_free    = !r_out_valid || o_out.ready;
    assign ex_fire     = r_in_valid && out_free;
    assign i_in.ready  = !r_in_valid || ex_fire;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    // decode
    always_comb begin
        op       = r_in.op;
        dst_code = op[5:3];
        src_code = op[2:0];
        dst_idx  = code_to_index(dst_code);
        src_idx  = code_to_index(src_code);
        src_val  = r_regs[src_idx];
        alu_kind = t_alu_op'(op[5:3]);
        // LD r,A only for r = A; no (HL) loads
        ld_ok    = (op[7:6] == OPG_LOAD) && (dst_code != CODE_HL) && (src_code != CODE_HL)
                   && ((src_code != CODE_A) || (dst_code == CODE_A));
        alu_en   = (op[7:6] == OPG_ALU_REG)
                   || ((op[7:6] == OPG_ALU_IMM) && (src_code == CODE_HL));
        alu_b    = (src_code == CODE_HL) ? r_in.operand : src_val;
        write_a  = alu_en && (alu_kind != ALU_CP);
    end

    cra_alu u_alu (
        .i_kind   (alu_kind),
        .i_a      (r_regs[REG_A]),
        .i_b      (alu_b),
        .i_carry  (r_flags.c),
        .o_result (alu_res),
        .o_flags  (alu_flags)
    );

    always_comb begin
        n_flags = alu_en ? alu_flags : r_flags;
        n_h     = (ld_ok && dst_idx == REG_H) ? src_val : r_regs[REG_H];
        n_l     = (ld_ok && dst_idx == REG_L) ? src_val : r_regs[REG_L];

        n_out.result_value    = ld_ok ? src_val : (alu_en ? alu_res : 8'd0);
        n_out.zero_flag       = n_flags.z;
        n_out.subtract_flag   = n_flags.n;
        n_out.half_carry_flag = n_flags.h;
        n_out.carry_flag      = n_flags.c;
        n_out.hl_address      = {n_h, n_l};
        n_out.known           = ld_ok || alu_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (ex_fire) begin
                r_in_valid <= 1'b0;
            end

            if (ex_fire) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
                if (ld_ok) begin
                    r_regs[dst_idx] <= src_val;
                end
                if (write_a) begin
                    r_regs[REG_A] <= alu_res;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payloads
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (ex_fire) begin
            r_out <= n_out;
        end
    end

    `CRA_ASSERT_NEXT(a_exec_fills_out, i_clk, i_rst_n, ex_fire, r_out_valid, "executed item lost")
    `CRA_ASSERT_NEXT(a_pending_kept, i_clk, i_rst_n, r_in_valid && !ex_fire, r_in_valid, "pending item dropped")
    `CRA_ASSERT_NEXT(a_unknown_keeps_flags, i_clk, i_rst_n, ex_fire && !ld_ok && !alu_en, $stable(r_flags), "unknown op changed flags")
    `CRA_ASSERT_IMPL(a_unknown_zero_value, i_clk, i_rst_n, r_out_valid && !r_out.known, r_out.result_value == 8'd0, "unknown op gave nonzero value")

endmodule

// ----- design/cra_alu.sv -----
// 8-bit ALU: add/sub with carry, logic ops, compare, and Z/N/H/C flags.
`timescale 1ns / 1ps

module cra_alu (
    input  cra_pkg::t_alu_op i_kind,
    input  logic [7:0]       i_a,
    input  logic [7:0]       i_b,
    input  logic             i_carry,
    output logic [7:0]       o_result,
    output cra_pkg::t_flags  o_flags
);
    import cra_pkg::*;

    logic [8:0] sum9;
    logic [4:0] nib5;
    logic       cin;

    always_comb begin
        sum9     = '0;
        nib5     = '0;
        cin      = 1'b0;
        o_result = '0;
        o_flags  = '0;
        case (i_kind)
            ALU_ADD, ALU_ADC: begin
                cin       = (i_kind == ALU_ADC) ? i_carry : 1'b0;
                sum9      = {1'b0, i_a} + {1'b0, i_b} + {8'd0, cin};
                nib5      = {1'b0, i_a[3:0]} + {1'b0, i_b[3:0]} + {4'd0, cin};
                o_result  = sum9[7:0];
                o_flags.h = nib5[4];
                o_flags.c = sum9[8];
            end
            ALU_SUB, ALU_SBC, ALU_CP: begin
                // bit 8 / bit 4 of the wrapped difference is the borrow
                cin       = (i_kind == ALU_SBC) ? i_carry : 1'b0;
                sum9      = {1'b0, i_a} - {1'b0, i_b} - {8'd0, cin};
                nib5      = {1'b0, i_a[3:0]} - {1'b0, i_b[3:0]} - {4'd0, cin};
                o_result  = sum9[7:0];
                o_flags.n = 1'b1;
                o_flags.h = nib5[4];
                o_flags.c = sum9[8];
            end
            ALU_AND: begin
                o_result  = i_a & i_b;
                o_flags.h = 1'b1;
            end
            ALU_XOR: begin
                o_result = i_a ^ i_b;
            end
            ALU_OR: begin
                o_result = i_a | i_b;
            end
            default: begin
                o_result = '0;
            end
        endcase
        o_flags.z = (o_result == 8'd0);
    end

endmodule
